### design/slcfr_pkg.sv
// Package: shared types and constants for the sync/length/checksum frame receiver.
package slcfr_pkg;

	typedef logic [7:0] byte_t;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_ID    = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_CHK   = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_HEADER  = 3'd1,
		EV_PAYLOAD = 3'd2,
		EV_GOOD    = 3'd3,
		EV_BAD     = 3'd4,
		EV_TOOLONG = 3'd5
	} event_t;

	localparam int unsigned CfgIdxW = 2;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_FIRST_SYNC  = 2'd0;
	localparam cfg_idx_t CFG_SECOND_SYNC = 2'd1;
	localparam cfg_idx_t CFG_MAX_LENGTH  = 2'd2;

	localparam byte_t FIRST_SYNC_RST  = 8'hAA;
	localparam byte_t SECOND_SYNC_RST = 8'hAF;
	localparam byte_t MAX_LENGTH_RST  = 8'd128;

	typedef struct packed {
		event_t ev;
		byte_t  pbyte;
		byte_t  pidx;
		byte_t  id;
		byte_t  flen;
	} res_t;

endpackage

### design/slcfr_if.sv
// Interfaces: input byte channel and result channel, valid/ready handshake.
interface slcfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcfr_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [7:0] message_id;
	logic [7:0] frame_length;

	modport source (output valid, output event_res, output payload_byte,
		output payload_index, output message_id, output frame_length, input ready);
	modport sink   (input valid, input event_res, input payload_byte,
		input payload_index, input message_id, input frame_length, output ready);
endinterface

### design/slcfr_parser.sv
// Frame parser: configuration registers, frame state and per-beat result logic.
module slcfr_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  slcfr_pkg::cfg_idx_t cfg_index,
	input  slcfr_pkg::byte_t  cfg_data,
	input  logic              take,
	input  slcfr_pkg::byte_t  rx_byte,
	output slcfr_pkg::res_t   res
);
	import slcfr_pkg::*;

	byte_t  first_sync_q, second_sync_q, max_length_q;
	phase_t phase_q, phase_d;
	byte_t  sum_q, sum_d;
	byte_t  taken_q, taken_d;
	byte_t  explen_q, explen_d;
	byte_t  id_q, id_d;
	byte_t  sum_add;

	assign sum_add = sum_q + rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sync_q  <= FIRST_SYNC_RST;
			second_sync_q <= SECOND_SYNC_RST;
			max_length_q  <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_SYNC:  first_sync_q  <= cfg_data;
				CFG_SECOND_SYNC: second_sync_q <= cfg_data;
				CFG_MAX_LENGTH:  max_length_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		sum_d    = sum_q;
		taken_d  = taken_q;
		explen_d = explen_q;
		id_d     = id_q;
		case (phase_q)
			PH_HUNT: begin
				phase_d = (rx_byte == first_sync_q) ? PH_SYNC2 : PH_HUNT;
				sum_d   = rx_byte;
			end
			PH_SYNC2: begin
				phase_d = (rx_byte == second_sync_q) ? PH_ID : PH_HUNT;
				sum_d   = sum_add;
			end
			PH_ID: begin
				id_d    = rx_byte;
				phase_d = PH_LEN;
				sum_d   = sum_add;
			end
			PH_LEN: begin
				if (rx_byte <= max_length_q) begin
					explen_d = rx_byte;
					taken_d  = '0;
					phase_d  = (rx_byte != '0) ? PH_DATA : PH_CHK;
					sum_d    = sum_add;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_DATA: begin
				taken_d = taken_q + 8'd1;
				sum_d   = sum_add;
				if (taken_d == explen_q) begin
					phase_d = PH_CHK;
				end
			end
			PH_CHK: phase_d = PH_HUNT;
			default: phase_d = PH_HUNT;
		endcase
	end

	// result of this beat
	always_comb begin
		res.ev    = EV_NONE;
		res.pbyte = '0;
		res.pidx  = '0;
		res.id    = id_d;
		res.flen  = explen_q;
		case (phase_q)
			PH_LEN: begin
				if (rx_byte <= max_length_q) begin
					res.ev   = EV_HEADER;
					res.flen = rx_byte;
				end else begin
					res.ev   = EV_TOOLONG;
					res.flen = rx_byte;  // rejected length, stored length untouched
				end
			end
			PH_DATA: begin
				res.ev    = EV_PAYLOAD;
				res.pbyte = rx_byte;
				res.pidx  = taken_q;
			end
			PH_CHK: res.ev = (sum_q == rx_byte) ? EV_GOOD : EV_BAD;
			default: res.ev = EV_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			sum_q    <= '0;
			taken_q  <= '0;
			explen_q <= '0;
			id_q     <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			sum_q    <= sum_d;
			taken_q  <= taken_d;
			explen_q <= explen_d;
			id_q     <= id_d;
		end
	end

endmodule

### design/slcfr_out_reg.sv
// Result register: holds one result beat and frees itself when the sink takes it.
module slcfr_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  slcfr_pkg::res_t res_in,
	input  logic            out_ready,
	output logic            free,
	output logic            out_valid,
	output slcfr_pkg::res_t res_out
);
	import slcfr_pkg::*;

	logic valid_q;
	res_t res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

### design/sync_len_checksum_frame_receiver_top.sv
// Top level: two-sync-byte, length-prefixed frame receiver with additive checksum.
//
//  channel | dir | handshake     | payload
//  rx      | in  | valid/ready   | rx_byte
//  res     | out | valid/ready   | event_res, payload_byte, payload_index,
//          |     |               | message_id, frame_length
//  cfg     | in  | cfg_we only   | cfg_index, cfg_data
//
// One beat a cycle unless a stalled result holds rx: a byte is parsed in the cycle
// it is taken and its result sits in the output register the next cycle.
// rx.ready is high while the output register is empty or being emptied.
// Reset puts the parser in sync hunt with the register defaults loaded.
// A stalled result stalls rx; nothing is lost or repeated.
module sync_len_checksum_frame_receiver_top (
	input  logic                clk,
	input  logic                arst_n,
	slcfr_byte_if.sink          rx,
	slcfr_res_if.source         res,
	input  logic                cfg_we,
	input  slcfr_pkg::cfg_idx_t cfg_index,
	input  slcfr_pkg::byte_t    cfg_data
);
	import slcfr_pkg::*;

	logic take;
	logic free;
	res_t res_comb;
	res_t res_reg;

	assign rx.ready = free;
	assign take     = rx.valid && free;

	slcfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.rx_byte   (rx.rx_byte),
		.res       (res_comb)
	);

	slcfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.res_in    (res_comb),
		.out_ready (res.ready),
		.free      (free),
		.out_valid (res.valid),
		.res_out   (res_reg)
	);

	assign res.event_res     = res_reg.ev;
	assign res.payload_byte  = res_reg.pbyte;
	assign res.payload_index = res_reg.pidx;
	assign res.message_id    = res_reg.id;
	assign res.frame_length  = res_reg.flen;

	a_no_take_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |-> !rx.ready)
		else $error("byte taken while result stalled");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.event_res != EV_PAYLOAD) |->
		(res.payload_byte == '0 && res.payload_index == '0))
		else $error("payload fields set outside a payload beat");

	a_take_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready) |=> res.valid)
		else $error("accepted byte gave no result");

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.event_res <= EV_TOOLONG))
		else $error("event code out of range");

endmodule
